FILE: rtl/core/bfrc_pkg.sv
package bfrc_pkg;

  // field widths of the stream words
  localparam int OCC_W      = 24;
  localparam int GAMMA_W    = 16;
  localparam int S_TDATA_W  = 2 * OCC_W + GAMMA_W;
  localparam int RATE_W     = 16;
  localparam int M_TUSER_W  = 2;

  // configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // fixed point: Q16.16 factors, gamma counted in 4096-byte units
  localparam int FRAC_W      = 16;
  localparam int GAMMA_SHIFT = 12;

  // update rules
  typedef enum logic [1:0] {
    MODE_ADD_SUB   = 2'd0,
    MODE_ADD_MUL   = 2'd1,
    MODE_PROP      = 2'd2,
    MODE_PROP_DAMP = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_ALPHA     = 3'd1,
    CFG_DELTA     = 3'd2,
    CFG_EPSILON   = 3'd3,
    CFG_BETA      = 3'd4,
    CFG_PAYLOAD   = 3'd5,
    CFG_INIT_RATE = 3'd6
  } cfg_reg_t;

endpackage

FILE: rtl/core/buffer_feedback_rate_controller.sv
// Send-rate controller driven by receiver buffer feedback.
// Slave stream s_axis: one feedback word per update (occupancy, target
// occupancy, gamma term). Master stream m_axis: one result word per feedback
// word, the new rate in tdata and the floored / saturated flags in tuser.
// Configuration channel cfg_*: register index and data, always ready; write
// only while no feedback word is in flight. Writing init_rate reloads the
// rate state (0 loads 1, values above RATE_MAX load RATE_MAX).
// Path from accept to result valid, through one shift-add unit and one
// restoring divider doing one bit per cycle:
//   mode 0, or a zero error / positive error in mode 1: straight to the clamp
//   mode 1 with negative error: 32-bit serial multiply, then the clamp
//   modes 2 and 3: 16 + 32 + 32 multiply steps, then QW divide steps
//   (QW = $clog2(RATE_MAX+1) + 34 for RATE_MAX >= 4096), the sum and the clamp
// One word is worked on at a time; s_axis_tready is high while idle.
// A finished result sits in the output register; the next word is accepted
// meanwhile, but its result waits in the last step until m_axis_tready.
// Reset loads the register defaults, rate 1, and clears the output valid.
module buffer_feedback_rate_controller #(
  parameter int unsigned RATE_MAX = 65535
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // occupancy, target_occupancy, gamma_units
  input  logic [bfrc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // new_rate
  output logic [bfrc_pkg::RATE_W-1:0]      m_axis_tdata,
  // floored, saturated
  output logic [bfrc_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bfrc_pkg::*;

  localparam int RW   = $clog2(RATE_MAX + 1);
  localparam int EW   = OCC_W + 1;
  localparam int PW   = (RW + FRAC_W > GAMMA_W + GAMMA_SHIFT) ? RW + FRAC_W
                                                             : GAMMA_W + GAMMA_SHIFT;
  localparam int IW   = PW + 1;
  localparam int AW   = IW + CFG_DATA_W + 1;
  localparam int QW   = AW - FRAC_W;
  localparam int CW   = QW + 2;
  localparam int CNTW = $clog2(QW + 1);
  localparam int DW   = ((RW + FRAC_W > CFG_DATA_W) ? RW + FRAC_W : CFG_DATA_W) + 1;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SUM, S_CLAMP} state_t;
  typedef enum logic [1:0] {PH_INNER, PH_DAMP, PH_GAIN, PH_DECR} phase_t;

  state_t              state;
  phase_t              phase;
  logic [RW-1:0]       rate;
  mode_t               mode;
  logic [31:0]         alpha;
  logic [31:0]         delta;
  logic [31:0]         epsilon;
  logic [31:0]         beta;
  logic [15:0]         payload_bytes;
  logic [15:0]         p;
  logic [EW-1:0]       err;
  logic [AW-1:0]       acc;
  logic [AW-1:0]       mcand;
  logic [31:0]         mplier;
  logic [CNTW-1:0]     cnt;
  logic [QW-1:0]       dvd;
  logic [15:0]         rem;
  logic                neg;
  logic [CW-1:0]       cand;
  logic                m_valid;
  logic [RATE_W-1:0]   m_data;
  logic [M_TUSER_W-1:0] m_user;

  logic [OCC_W-1:0]    occ_in;
  logic [OCC_W-1:0]    tgt_in;
  logic [GAMMA_W-1:0]  gam_in;
  logic [EW-1:0]       in_err;
  logic [15:0]         p_in;
  logic [AW-1:0]       addend;
  logic [AW-1:0]       acc_new;
  logic [AW-1:0]       acc_mag;
  logic [17:0]         trial;
  logic                qbit;
  logic [DW-1:0]       dec_diff;
  logic [CW-1:0]       inc_sum;
  logic [CW-1:0]       q_ext;
  logic [CW-1:0]       cand_sum;
  logic                low;
  logic                over;
  logic [RW-1:0]       rate_clamp;
  logic [RW+15:0]      rate_ext;
  logic [RW+15:0]      init_wide;
  logic [RW-1:0]       init_clamp;

  // unpack feedback word
  assign occ_in = s_axis_tdata[OCC_W-1:0];
  assign tgt_in = s_axis_tdata[2*OCC_W-1:OCC_W];
  assign gam_in = s_axis_tdata[S_TDATA_W-1:2*OCC_W];
  assign in_err = {1'b0, tgt_in} - {1'b0, occ_in};
  assign p_in   = (payload_bytes == 16'd0) ? 16'd1 : payload_bytes;

  // shift-add step, subtracting in the damping pass
  assign addend  = mplier[0] ? mcand : '0;
  assign acc_new = (phase == PH_DAMP) ? acc - addend : acc + addend;
  assign acc_mag = acc_new[AW-1] ? AW'(0) - acc_new : acc_new;

  // restoring divide step
  assign trial = {1'b0, rem, dvd[QW-1]} - {2'b0, p};
  assign qbit  = ~trial[17];

  // additive rules
  assign dec_diff = DW'({rate, 16'b0}) - DW'(alpha);
  assign inc_sum  = CW'(rate) + CW'(alpha[31:FRAC_W]);

  // rate plus signed quotient
  assign q_ext    = CW'(dvd);
  assign cand_sum = CW'(rate) + (neg ? CW'(0) - q_ext : q_ext);

  // floor and saturation
  assign low  = cand[CW-1] || (cand == '0);
  assign over = !cand[CW-1] && (cand > CW'(RATE_MAX));
  always_comb begin
    if (low) begin
      rate_clamp = RW'(1);
    end else if (over) begin
      rate_clamp = RW'(RATE_MAX);
    end else begin
      rate_clamp = cand[RW-1:0];
    end
  end
  assign rate_ext = {16'b0, rate_clamp};

  // init_rate reload value
  assign init_wide = {RW'(0), cfg_data[15:0]};
  always_comb begin
    if (init_wide == '0) begin
      init_clamp = RW'(1);
    end else if (init_wide > (RW + 16)'(RATE_MAX)) begin
      init_clamp = RW'(RATE_MAX);
    end else begin
      init_clamp = init_wide[RW-1:0];
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tuser  = m_user;

  // sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_INNER;
      rate          <= RW'(1);
      mode          <= MODE_ADD_SUB;
      alpha         <= 32'd65536;
      delta         <= 32'd32768;
      epsilon       <= 32'd65536;
      beta          <= 32'd0;
      payload_bytes <= 16'd1024;
      m_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MODE:      mode          <= mode_t'(cfg_data[1:0]);
          CFG_ALPHA:     alpha         <= cfg_data;
          CFG_DELTA:     delta         <= cfg_data;
          CFG_EPSILON:   epsilon       <= cfg_data;
          CFG_BETA:      beta          <= cfg_data;
          CFG_PAYLOAD:   payload_bytes <= cfg_data[15:0];
          CFG_INIT_RATE: rate          <= init_clamp;
          default: ;
        endcase
      end

      if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            err <= in_err;
            p   <= p_in;
            if (mode inside {MODE_ADD_SUB, MODE_ADD_MUL}) begin
              if (in_err == '0) begin
                cand  <= CW'(rate);
                state <= S_CLAMP;
              end else if (!in_err[EW-1]) begin
                cand  <= inc_sum;
                state <= S_CLAMP;
              end else if (mode == MODE_ADD_SUB) begin
                cand  <= dec_diff[DW-1] ? '0 : CW'(dec_diff[DW-2:FRAC_W]);
                state <= S_CLAMP;
              end else begin
                acc    <= '0;
                mcand  <= AW'(rate);
                mplier <= delta;
                cnt    <= CNTW'(32);
                phase  <= PH_DECR;
                state  <= S_MUL;
              end
            end else begin
              // inner = rate*payload - gamma*4096, start from -gamma*4096
              acc    <= AW'(0) - AW'({gam_in, {GAMMA_SHIFT{1'b0}}});
              mcand  <= AW'(rate);
              mplier <= 32'(p_in);
              cnt    <= CNTW'(16);
              phase  <= PH_INNER;
              state  <= S_MUL;
            end
          end
        end

        S_MUL: begin
          acc    <= acc_new;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            case (phase)
              PH_INNER: begin
                acc    <= '0;
                mcand  <= acc_new;
                mplier <= (mode == MODE_PROP_DAMP) ? beta : 32'd0;
                cnt    <= CNTW'(32);
                phase  <= PH_DAMP;
              end
              PH_DAMP: begin
                mcand  <= {{(AW - EW){err[EW-1]}}, err};
                mplier <= epsilon;
                cnt    <= CNTW'(32);
                phase  <= PH_GAIN;
              end
              PH_GAIN: begin
                neg   <= acc_new[AW-1];
                dvd   <= acc_mag[AW-1:FRAC_W];
                rem   <= '0;
                cnt   <= CNTW'(QW);
                state <= S_DIV;
              end
              PH_DECR: begin
                cand  <= CW'(acc_new[AW-2:FRAC_W]);
                state <= S_CLAMP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_DIV: begin
          dvd <= {dvd[QW-2:0], qbit};
          rem <= qbit ? trial[15:0] : {rem[14:0], dvd[QW-1]};
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= S_SUM;
          end
        end

        S_SUM: begin
          cand  <= cand_sum;
          state <= S_CLAMP;
        end

        S_CLAMP: begin
          if (!m_valid || m_axis_tready) begin
            rate    <= rate_clamp;
            m_valid <= 1'b1;
            m_data  <= rate_ext[RATE_W-1:0];
            m_user  <= {over, low};
            state   <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // rate state stays within 1..RATE_MAX
  assert property (@(posedge clk) disable iff (rst)
    (rate != '0) && (32'(rate) <= RATE_MAX))
    else $error("rate state out of range");

  // a result is never both floored and saturated
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("floored and saturated both set");

  // a floored result carries rate 1
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == RATE_W'(1)))
    else $error("floored result is not 1");

  // partial remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < p))
    else $error("divider remainder not below payload size");

  // a pending result is not overwritten while stalled
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule
